@@ rtl/mi3_pkg.sv @@
package mi3_pkg;

  localparam int unsigned DW     = 16;
  localparam int unsigned NEL    = 9;
  localparam int unsigned PW     = 2 * DW;
  localparam int unsigned CW     = PW + 1;
  localparam int unsigned TW     = DW + CW;
  localparam int unsigned DTW    = TW + 2;
  localparam int unsigned MW     = DTW - 1;
  localparam int unsigned LW     = 25;
  localparam int unsigned QW     = DW;
  localparam int unsigned LAT    = 5 + QW + 2;
  localparam logic [LW-1:0] LIMIT_RST = LW'(16777);
  localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef logic [NEL-1:0][DW-1:0] mat_t;
  typedef logic [NEL-1:0][CW-1:0] cof_t;
  typedef logic [2:0][DW-1:0]     row_t;

  typedef struct packed {
    logic [MW-1:0] mag;
    logic          neg;
    logic          sing;
  } det_info_t;

endpackage

@@ rtl/matrix3x3_inverse_core.sv @@
// 3x3 matrix inverse, signed Q8.8 in and out.
// Input channel s_axis: one item is a full matrix, nine 16-bit elements a00..a22.
// Output channel m_axis: one item is the inverse inv00..inv22 in tdata and the
// singular flag in tuser; singular items carry all-zero elements.
// cfg_we_i/cfg_wdata_i write the 25-bit singular limit on |det| (units 2^-24).
// From accept to m_axis_tvalid an item passes two stages of products
// and cofactors, three for the determinant and its magnitude compare, one
// divider setup stage, sixteen restoring divider stages (one quotient bit
// each), and one saturate stage.
// Throughput is one item per cycle when unstalled; all stages move together.
// A stall on m_axis_tready freezes every stage and drops s_axis_tready in the
// same cycle, so no item is lost or repeated; bubbles are not squeezed out.
// Reset clears all valid bits and loads the limit with 16777.
module matrix3x3_inverse_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [143:0]  s_axis_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // inv00,inv01,...,inv22
  output logic [0:0]    m_axis_tuser,   // singular
  input  logic          cfg_we_i,
  input  logic [24:0]   cfg_wdata_i
);
  import mi3_pkg::*;

  logic [LW-1:0]  limit_q;
  logic [LAT-1:0] vld_q;
  logic           en;
  mat_t           a_w;
  cof_t           cof_w, cofd_w;
  row_t           row0_w;
  det_info_t      info_w;
  logic [NEL-1:0] sing_w;

  assign a_w           = s_axis_tdata;
  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tuser  = sing_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  mi3_cof u_cof (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (a_w),
    .cof_o  (cof_w),
    .row0_o (row0_w)
  );

  mi3_det u_det (
    .clk_i   (clk_i),
    .en_i    (en),
    .limit_i (limit_q),
    .cof_i   (cof_w),
    .row0_i  (row0_w),
    .cof_o   (cofd_w),
    .info_o  (info_w)
  );

  for (genvar r = 0; r < 3; r++) begin : g_r
    for (genvar c = 0; c < 3; c++) begin : g_c
      mi3_div u_div (
        .clk_i  (clk_i),
        .en_i   (en),
        .cof_i  (cofd_w[c*3+r]),
        .info_i (info_w),
        .res_o  (m_axis_tdata[(r*3+c)*DW +: DW]),
        .sing_o (sing_w[r*3+c])
      );
    end
  end

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (sing_w == '0 || sing_w == '1))
    else $error("divider lanes disagree on singular flag");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("singular item carries nonzero elements");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted item missing from first stage");

endmodule

@@ rtl/mi3_cof.sv @@
module mi3_cof (
  input  logic          clk_i,
  input  logic          en_i,
  input  mi3_pkg::mat_t a_i,
  output mi3_pkg::cof_t cof_o,
  output mi3_pkg::row_t row0_o
);
  import mi3_pkg::*;

  logic signed [PW-1:0] pa_q [NEL];
  logic signed [PW-1:0] pb_q [NEL];
  row_t                 row_q1, row_q2;
  cof_t                 cof_q;

  for (genvar r = 0; r < 3; r++) begin : g_r
    for (genvar c = 0; c < 3; c++) begin : g_c
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      logic signed [PW-1:0] pa_d, pb_d;
      logic signed [CW-1:0] cof_d;
      assign pa_d = $signed(a_i[R1*3+C1]) * $signed(a_i[R2*3+C2]);
      assign pb_d = $signed(a_i[R1*3+C2]) * $signed(a_i[R2*3+C1]);
      assign cof_d = CW'(pa_q[r*3+c]) - CW'(pb_q[r*3+c]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pa_q[r*3+c]  <= pa_d;
          pb_q[r*3+c]  <= pb_d;
          cof_q[r*3+c] <= cof_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q1 <= {a_i[2], a_i[1], a_i[0]};
      row_q2 <= row_q1;
    end
  end

  assign cof_o  = cof_q;
  assign row0_o = row_q2;

endmodule

@@ rtl/mi3_det.sv @@
module mi3_det (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [mi3_pkg::LW-1:0] limit_i,
  input  mi3_pkg::cof_t          cof_i,
  input  mi3_pkg::row_t          row0_i,
  output mi3_pkg::cof_t          cof_o,
  output mi3_pkg::det_info_t     info_o
);
  import mi3_pkg::*;

  logic signed [TW-1:0]  t_q [3];
  logic signed [DTW-1:0] det_q;
  logic signed [DTW-1:0] det_d;
  logic [DTW-1:0]        abs_d;
  cof_t                  cof_q1, cof_q2, cof_q3;
  det_info_t             info_q, info_d;

  for (genvar c = 0; c < 3; c++) begin : g_t
    logic signed [TW-1:0] t_d;
    assign t_d = $signed(row0_i[c]) * $signed(cof_i[c]);
    always_ff @(posedge clk_i) begin
      if (en_i) t_q[c] <= t_d;
    end
  end

  assign det_d = DTW'(t_q[0]) + DTW'(t_q[1]) + DTW'(t_q[2]);
  assign abs_d = det_q[DTW-1] ? DTW'(-det_q) : DTW'(det_q);

  always_comb begin
    info_d.mag  = abs_d[MW-1:0];
    info_d.neg  = det_q[DTW-1];
    info_d.sing = info_d.mag <= MW'(limit_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cof_q1 <= cof_i;
      det_q  <= det_d;
      cof_q2 <= cof_q1;
      info_q <= info_d;
      cof_q3 <= cof_q2;
    end
  end

  assign cof_o  = cof_q3;
  assign info_o = info_q;

endmodule

@@ rtl/mi3_div.sv @@
module mi3_div (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [mi3_pkg::CW-1:0] cof_i,
  input  mi3_pkg::det_info_t     info_i,
  output logic [mi3_pkg::DW-1:0] res_o,
  output logic                   sing_o
);
  import mi3_pkg::*;

  logic [MW-1:0] r_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic [MW-1:0] d_q   [QW+1];
  logic          ovf_q [QW+1];
  logic          neg_q [QW+1];
  logic          sng_q [QW+1];
  logic [CW-1:0] ca_d;
  logic [DW-1:0] res_d;
  logic [DW-1:0] res_q;
  logic          sing_q;

  assign ca_d = cof_i[CW-1] ? -cof_i : cof_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= MW'(ca_d);
      q_q[0]   <= '0;
      d_q[0]   <= info_i.mag;
      ovf_q[0] <= MW'(ca_d) >= info_i.mag;
      neg_q[0] <= cof_i[CW-1] ^ info_i.neg;
      sng_q[0] <= info_i.sing;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [MW:0] rr_d, df_d;
    logic        ge_d;
    assign rr_d = {r_q[k], 1'b0};
    assign df_d = rr_d - {1'b0, d_q[k]};
    assign ge_d = rr_d >= {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge_d ? df_d[MW-1:0] : rr_d[MW-1:0];
        q_q[k+1]   <= {q_q[k][QW-2:0], ge_d};
        d_q[k+1]   <= d_q[k];
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
        sng_q[k+1] <= sng_q[k];
      end
    end
  end

  always_comb begin
    if (sng_q[QW]) begin
      res_d = '0;
    end else if (neg_q[QW]) begin
      if (ovf_q[QW] || (q_q[QW] > Q_MIN)) res_d = Q_MIN;
      else res_d = DW'(-q_q[QW]);
    end else begin
      if (ovf_q[QW] || q_q[QW][QW-1]) res_d = Q_MAX;
      else res_d = q_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      sing_q <= sng_q[QW];
    end
  end

  assign res_o  = res_q;
  assign sing_o = sing_q;

endmodule
